// ===== rtl/tvnf_pkg.sv =====
// Shared types and constants of the tiling value noise fBm block.
// No dependencies; every module of the block imports this package.
`default_nettype none

package tvnf_pkg;

   // Default values of the top-level parameters
   localparam int MAX_OCTAVES_DEFAULT = 8;
   localparam int COORD_BITS_DEFAULT  = 16;

   // Field and register widths
   localparam int COORD_W  = 16;
   localparam int FREQ_W   = 11;
   localparam int CNT_W    = 4;
   localparam int SEED_W   = 32;
   localparam int NOISE_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Internal number formats
   localparam int FRAC_W    = 16;   // cell offset fraction
   localparam int SQ_W      = 32;   // offset squared
   localparam int FADE_K_W  = 18;   // 3 - 2t on a 16-bit scale
   localparam int FADE_S_W  = 49;   // exact smoothstep value
   localparam int WEIGHT_W  = 17;   // fade weight in [0, 65536]
   localparam int HASH_W    = 32;
   localparam int CORNER_W  = 24;
   localparam int PROD_W    = CORNER_W + WEIGHT_W;
   localparam int BLEND_W   = PROD_W + 1;

   // Pipeline depth of one octave lane, counted from the coordinate stage
   localparam int LANE_LAT = 7;

   // Lattice hash multipliers
   localparam logic [HASH_W-1:0] HASH_MUL_X    = 32'd374761393;
   localparam logic [HASH_W-1:0] HASH_MUL_Y    = 32'd668265263;
   localparam logic [HASH_W-1:0] HASH_MUL_SEED = 32'd2246822519;
   localparam logic [HASH_W-1:0] HASH_MUL_MIX  = 32'd1274126177;
   localparam int unsigned       SEED_STEP     = 17;

   // Fixed-point helpers
   localparam logic [FADE_K_W-1:0] FADE_THREE  = 18'd196608;
   localparam logic [FADE_S_W-1:0] FADE_HALF   = 49'd2147483648;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 17'd65536;
   localparam logic [BLEND_W-1:0]  BLEND_HALF  = 42'd32768;

   // Register reset values
   localparam logic [FREQ_W-1:0] BASE_FREQ_RESET    = 11'd4;
   localparam logic [CNT_W-1:0]  OCTAVE_COUNT_RESET = 4'd4;
   localparam logic [SEED_W-1:0] HASH_SEED_RESET    = 32'd2654435769;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_FREQUENCY = 2'd0,
      CSR_OCTAVE_COUNT   = 2'd1,
      CSR_HASH_SEED      = 2'd2
   } csr_index_type;

   // Configuration as seen by the datapath (frequency zero already mapped to one)
   typedef struct packed {
      logic [FREQ_W-1:0] base_frequency;
      logic [CNT_W-1:0]  octave_count;
      logic [SEED_W-1:0] hash_seed;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/tiling_value_noise_fbm.sv =====
// Top level of the tiling value noise fBm block: configuration registers,
// coordinate stage, one tvnf_octave lane per octave and tvnf_accum.
// Usage:
//   Drive req_coord_u/req_coord_v and raise start; the transaction is taken
//   at a rising edge where start is high and busy is low. busy is high only
//   in reset and the cycle after, so a new coordinate can enter every cycle.
//   Each transaction gives one result: once it has passed the coordinate
//   stage, the lane stages and the sum stages, rsp_strobe stays high for one
//   cycle with rsp_noise_value. Results leave in order at one per cycle; the
//   receiver has to take them as they come.
//   Pipeline: one coordinate stage loaded at the accepting edge (coordinate
//   times base frequency, seed times hash constant), seven stages of the
//   octave lanes (hash multiplies, smoothstep fade and two blend multiplies,
//   one register after each), and three stages of the octave sum and rounding.
//   All octaves run in parallel lanes, so the octave count does not change
//   latency or throughput.
//   Configuration: write csr_write_data to register csr_index with
//   csr_write_enable; index 0 base frequency, 1 octave count, 2 hash seed.
//   Write only while no transaction is in flight.
//   Reset (synchronous) restores the register defaults and empties the pipe.
`default_nettype none

module tiling_value_noise_fbm import tvnf_pkg::*; #(
   parameter int MAX_OCTAVES = MAX_OCTAVES_DEFAULT,
   parameter int COORD_BITS  = COORD_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [COORD_W-1:0]    req_coord_u,
   input  wire logic [COORD_W-1:0]    req_coord_v,
   output logic                       rsp_strobe,
   output logic      [NOISE_W-1:0]    rsp_noise_value,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int USE_W    = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
   localparam int SCALED_W = USE_W + FREQ_W;

   cfg_type cfg;

   tvnf_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // ---------------- control: busy and valid pipe
   logic                busy_ff;
   logic                accept;
   logic [LANE_LAT:0]   valid_ff, valid_in;

   assign accept   = start & ~busy_ff;
   assign valid_in = {valid_ff[LANE_LAT-1:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         valid_ff <= '0;
      end else begin
         busy_ff  <= 1'b0;
         valid_ff <= valid_in;
      end
   end

   assign busy = busy_ff;

   // ---------------- stage A: scale coordinates, premultiply the seed
   logic [SCALED_W-1:0] scaled_u_ff, scaled_u_in, scaled_v_ff, scaled_v_in;
   logic [HASH_W-1:0]   seed_mult_ff, seed_mult_in;

   assign scaled_u_in  = SCALED_W'(req_coord_u[USE_W-1:0]) * SCALED_W'(cfg.base_frequency);
   assign scaled_v_in  = SCALED_W'(req_coord_v[USE_W-1:0]) * SCALED_W'(cfg.base_frequency);
   assign seed_mult_in = cfg.hash_seed * HASH_MUL_SEED;

   always_ff @(posedge clock) begin
      if (accept) begin
         scaled_u_ff  <= scaled_u_in;
         scaled_v_ff  <= scaled_v_in;
         seed_mult_ff <= seed_mult_in;
      end
   end

   // ---------------- octave lanes
   logic [CORNER_W-1:0] oct_value [MAX_OCTAVES];

   generate
      for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_lane
         tvnf_octave #(
            .COORD_BITS (COORD_BITS),
            .SCALED_W   (SCALED_W),
            .OCT        (g)
         ) u_octave (
            .clock     (clock),
            .cfg       (cfg),
            .scaled_u  (scaled_u_ff),
            .scaled_v  (scaled_v_ff),
            .seed_mult (seed_mult_ff),
            .oct_value (oct_value[g])
         );
      end
   endgenerate

   // ---------------- weighted sum and result
   tvnf_accum #(
      .MAX_OCTAVES (MAX_OCTAVES)
   ) u_accum (
      .clock           (clock),
      .reset           (reset),
      .oct_valid       (valid_ff[LANE_LAT]),
      .octave_count    (cfg.octave_count),
      .oct_value       (oct_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_noise_value (rsp_noise_value)
   );

endmodule

`default_nettype wire

// ===== rtl/tvnf_csr.sv =====
// Configuration registers of the tiling value noise fBm block.
// Depends on tvnf_pkg for widths, register indexes and reset values.
`default_nettype none

module tvnf_csr import tvnf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   output cfg_type                    cfg
);

   logic [FREQ_W-1:0] base_frequency_ff, base_frequency_in;
   logic [CNT_W-1:0]  octave_count_ff, octave_count_in;
   logic [SEED_W-1:0] hash_seed_ff, hash_seed_in;

   always_comb begin
      base_frequency_in = base_frequency_ff;
      octave_count_in   = octave_count_ff;
      hash_seed_in      = hash_seed_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BASE_FREQUENCY: base_frequency_in = csr_write_data[FREQ_W-1:0];
            CSR_OCTAVE_COUNT:   octave_count_in   = csr_write_data[CNT_W-1:0];
            CSR_HASH_SEED:      hash_seed_in      = csr_write_data[SEED_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_frequency_ff <= BASE_FREQ_RESET;
         octave_count_ff   <= OCTAVE_COUNT_RESET;
         hash_seed_ff      <= HASH_SEED_RESET;
      end else begin
         base_frequency_ff <= base_frequency_in;
         octave_count_ff   <= octave_count_in;
         hash_seed_ff      <= hash_seed_in;
      end
   end

   // Treat a zero frequency as one cell per tile edge
   always_comb begin
      cfg.base_frequency = (base_frequency_ff == '0) ? FREQ_W'(1) : base_frequency_ff;
      cfg.octave_count   = octave_count_ff;
      cfg.hash_seed      = hash_seed_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/tvnf_octave.sv =====
// One octave lane: lattice indices, corner hashes, smoothstep fade and
// bilinear blend in seven register stages. Depends on tvnf_pkg.
`default_nettype none

module tvnf_octave import tvnf_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int SCALED_W   = COORD_W + FREQ_W,
   parameter int OCT        = 0
) (
   input  wire logic                 clock,
   input  cfg_type                   cfg,
   input  wire logic [SCALED_W-1:0]  scaled_u,
   input  wire logic [SCALED_W-1:0]  scaled_v,
   input  wire logic [HASH_W-1:0]    seed_mult,
   output logic      [CORNER_W-1:0]  oct_value
);

   localparam int PX_W = SCALED_W + OCT;
   localparam int XW   = PX_W - COORD_BITS;
   localparam int FW   = FREQ_W + OCT;
   localparam logic [63:0] SEED_OFS_WIDE = 64'(SEED_STEP * OCT) * 64'(HASH_MUL_SEED);
   localparam logic [HASH_W-1:0] SEED_OFS = SEED_OFS_WIDE[HASH_W-1:0];

   // ---------------- stage B: lattice index, hash terms, t squared
   logic [PX_W-1:0]   px, py;
   logic [XW-1:0]     x0, y0;
   logic [FW:0]       freq_ext, x0_inc, y0_inc;
   logic [FRAC_W-1:0] tx, ty;

   logic [HASH_W-1:0] x0c_ff, x0c_in, y0c_ff, y0c_in, seed_ff, seed_in;
   logic              wrapx_ff, wrapx_in, wrapy_ff, wrapy_in;
   logic [FRAC_W-1:0] tx_ff, ty_ff;
   logic [SQ_W-1:0]   txx_ff, txx_in, tyy_ff, tyy_in;

   assign px       = PX_W'(scaled_u) << OCT;
   assign py       = PX_W'(scaled_v) << OCT;
   assign x0       = px[PX_W-1:COORD_BITS];
   assign y0       = py[PX_W-1:COORD_BITS];
   assign freq_ext = (FW+1)'(cfg.base_frequency) << OCT;
   assign x0_inc   = (FW+1)'(x0) + (FW+1)'(1);
   assign y0_inc   = (FW+1)'(y0) + (FW+1)'(1);

   generate
      if (COORD_BITS >= FRAC_W) begin : g_frac_trunc
         assign tx = px[COORD_BITS-1 -: FRAC_W];
         assign ty = py[COORD_BITS-1 -: FRAC_W];
      end else begin : g_frac_pad
         assign tx = {px[COORD_BITS-1:0], {(FRAC_W-COORD_BITS){1'b0}}};
         assign ty = {py[COORD_BITS-1:0], {(FRAC_W-COORD_BITS){1'b0}}};
      end
   endgenerate

   assign wrapx_in = (x0_inc == freq_ext);
   assign wrapy_in = (y0_inc == freq_ext);
   assign x0c_in   = HASH_W'(x0) * HASH_MUL_X;
   assign y0c_in   = HASH_W'(y0) * HASH_MUL_Y;
   assign seed_in  = seed_mult + SEED_OFS;
   assign txx_in   = SQ_W'(tx) * SQ_W'(tx);
   assign tyy_in   = SQ_W'(ty) * SQ_W'(ty);

   always_ff @(posedge clock) begin
      x0c_ff   <= x0c_in;
      y0c_ff   <= y0c_in;
      seed_ff  <= seed_in;
      wrapx_ff <= wrapx_in;
      wrapy_ff <= wrapy_in;
      tx_ff    <= tx;
      ty_ff    <= ty;
      txx_ff   <= txx_in;
      tyy_ff   <= tyy_in;
   end

   // ---------------- stage C: corner hash sums, smoothstep product
   logic [HASH_W-1:0]   x1c, y1c;
   logic [FADE_K_W-1:0] kx, ky;
   logic [HASH_W-1:0]   h_ff [4];
   logic [HASH_W-1:0]   h_in [4];
   logic [FADE_S_W-1:0] sx_ff, sx_in, sy_ff, sy_in;

   // x1 = x0 + 1 wraps to zero at the tile edge, so its term vanishes
   assign x1c = wrapx_ff ? '0 : x0c_ff + HASH_MUL_X;
   assign y1c = wrapy_ff ? '0 : y0c_ff + HASH_MUL_Y;

   assign h_in[0] = x0c_ff + y0c_ff + seed_ff;
   assign h_in[1] = x1c    + y0c_ff + seed_ff;
   assign h_in[2] = x0c_ff + y1c    + seed_ff;
   assign h_in[3] = x1c    + y1c    + seed_ff;

   assign kx    = FADE_THREE - (FADE_K_W'(tx_ff) << 1);
   assign ky    = FADE_THREE - (FADE_K_W'(ty_ff) << 1);
   assign sx_in = FADE_S_W'(txx_ff) * FADE_S_W'(kx);
   assign sy_in = FADE_S_W'(tyy_ff) * FADE_S_W'(ky);

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         h_ff[k] <= h_in[k];
      end
      sx_ff <= sx_in;
      sy_ff <= sy_in;
   end

   // ---------------- stage D: hash mix multiply, fade rounding
   logic [HASH_W-1:0]   m_ff [4];
   logic [HASH_W-1:0]   m_in [4];
   logic [FADE_S_W-1:0] sx_round, sy_round;
   logic [WEIGHT_W-1:0] wx_ff, wx_in, wy_d_ff, wy_in;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         m_in[k] = (h_ff[k] ^ (h_ff[k] >> 13)) * HASH_MUL_MIX;
      end
   end

   assign sx_round = sx_ff + FADE_HALF;
   assign sy_round = sy_ff + FADE_HALF;
   assign wx_in    = sx_round[FADE_S_W-1:FADE_S_W-WEIGHT_W];
   assign wy_in    = sy_round[FADE_S_W-1:FADE_S_W-WEIGHT_W];

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         m_ff[k] <= m_in[k];
      end
      wx_ff   <= wx_in;
      wy_d_ff <= wy_in;
   end

   // ---------------- stage E: corner values, horizontal blend products
   logic [CORNER_W-1:0] corner [4];
   logic [WEIGHT_W-1:0] wx_inv;
   logic [PROD_W-1:0]   pa_ff [2];
   logic [PROD_W-1:0]   pa_in [2];
   logic [PROD_W-1:0]   pb_ff [2];
   logic [PROD_W-1:0]   pb_in [2];
   logic [WEIGHT_W-1:0] wy_e_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         corner[k] = CORNER_W'(m_ff[k] ^ (m_ff[k] >> 16));
      end
   end

   assign wx_inv   = WEIGHT_ONE - wx_ff;
   assign pa_in[0] = PROD_W'(corner[0]) * PROD_W'(wx_inv);
   assign pb_in[0] = PROD_W'(corner[1]) * PROD_W'(wx_ff);
   assign pa_in[1] = PROD_W'(corner[2]) * PROD_W'(wx_inv);
   assign pb_in[1] = PROD_W'(corner[3]) * PROD_W'(wx_ff);

   always_ff @(posedge clock) begin
      for (int k = 0; k < 2; k++) begin
         pa_ff[k] <= pa_in[k];
         pb_ff[k] <= pb_in[k];
      end
      wy_e_ff <= wy_d_ff;
   end

   // ---------------- stage F: round the row blends
   logic [BLEND_W-1:0]  row_sum [2];
   logic [CORNER_W-1:0] row_ff [2];
   logic [WEIGHT_W-1:0] wy_f_ff;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         row_sum[k] = BLEND_W'(pa_ff[k]) + BLEND_W'(pb_ff[k]) + BLEND_HALF;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 2; k++) begin
         row_ff[k] <= row_sum[k][FRAC_W +: CORNER_W];
      end
      wy_f_ff <= wy_e_ff;
   end

   // ---------------- stage G: vertical blend products
   logic [PROD_W-1:0] qa_ff, qa_in, qb_ff, qb_in;

   assign qa_in = PROD_W'(row_ff[0]) * PROD_W'(WEIGHT_ONE - wy_f_ff);
   assign qb_in = PROD_W'(row_ff[1]) * PROD_W'(wy_f_ff);

   always_ff @(posedge clock) begin
      qa_ff <= qa_in;
      qb_ff <= qb_in;
   end

   // ---------------- stage H: round the octave value
   logic [BLEND_W-1:0]  col_sum;
   logic [CORNER_W-1:0] oct_ff;

   assign col_sum = BLEND_W'(qa_ff) + BLEND_W'(qb_ff) + BLEND_HALF;

   always_ff @(posedge clock) begin
      oct_ff <= col_sum[FRAC_W +: CORNER_W];
   end

   assign oct_value = oct_ff;

endmodule

`default_nettype wire

// ===== rtl/tvnf_accum.sv =====
// Weighted octave sum, rounding and saturation of the fBm result.
// Three register stages; depends on tvnf_pkg for widths.
`default_nettype none

module tvnf_accum import tvnf_pkg::*; #(
   parameter int MAX_OCTAVES = MAX_OCTAVES_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                oct_valid,
   input  wire logic [CNT_W-1:0]    octave_count,
   input  wire logic [CORNER_W-1:0] oct_value [MAX_OCTAVES],
   output logic                     rsp_strobe,
   output logic      [NOISE_W-1:0]  rsp_noise_value
);

   localparam int SUM_W  = CORNER_W + MAX_OCTAVES;
   localparam int PAIR_N = (MAX_OCTAVES + 1) / 2;
   localparam logic [SUM_W:0] ROUND_HALF = (SUM_W+1)'(1) << (SUM_W - NOISE_W - 1);

   // ---------------- stage I: weight octaves, add them in pairs
   logic [SUM_W-1:0] term   [MAX_OCTAVES];
   logic [SUM_W-1:0] pair_in [PAIR_N];
   logic [SUM_W-1:0] pair_ff [PAIR_N];
   logic             valid_i_ff, valid_j_ff, strobe_ff;

   always_comb begin
      for (int i = 0; i < MAX_OCTAVES; i++) begin
         // drop octaves beyond the programmed count
         if (CNT_W'(i) < octave_count) begin
            term[i] = SUM_W'(oct_value[i]) << (MAX_OCTAVES - 1 - i);
         end else begin
            term[i] = '0;
         end
      end
      for (int k = 0; k < PAIR_N; k++) begin
         pair_in[k] = '0;
      end
      for (int i = 0; i < MAX_OCTAVES; i++) begin
         pair_in[i >> 1] = pair_in[i >> 1] + term[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < PAIR_N; k++) begin
         pair_ff[k] <= pair_in[k];
      end
   end

   // ---------------- stage J: total
   logic [SUM_W-1:0] sum_ff, sum_in;

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < PAIR_N; k++) begin
         sum_in = sum_in + pair_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // ---------------- stage K: round half up to 16 bits, saturate
   logic [SUM_W:0]     rounded;
   logic [NOISE_W:0]   rounded_top;
   logic [NOISE_W-1:0] noise_ff, noise_in;

   assign rounded     = (SUM_W+1)'(sum_ff) + ROUND_HALF;
   assign rounded_top = rounded[SUM_W -: (NOISE_W+1)];
   assign noise_in    = rounded_top[NOISE_W] ? '1 : rounded_top[NOISE_W-1:0];

   always_ff @(posedge clock) begin
      noise_ff <= noise_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_i_ff <= 1'b0;
         valid_j_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         valid_i_ff <= oct_valid;
         valid_j_ff <= valid_i_ff;
         strobe_ff  <= valid_j_ff;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_noise_value = noise_ff;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for tiling_value_noise_fbm: directed and random
// coordinates under many register settings, checked against a built-in predictor.
// Depends on rtl/tvnf_pkg.sv and rtl/tiling_value_noise_fbm.sv.
`timescale 1ns / 100ps

module tb_top;
   import tvnf_pkg::*;

   localparam logic [31:0] K_X    = 32'd374761393;
   localparam logic [31:0] K_Y    = 32'd668265263;
   localparam logic [31:0] K_SEED = 32'd2246822519;
   localparam logic [31:0] K_MIX  = 32'd1274126177;
   localparam int unsigned K_STEP = 17;
   localparam int unsigned OCT_LIMIT = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct {
      logic [COORD_W-1:0] u;
      logic [COORD_W-1:0] v;
      int                 gap;
      bit                 drain;
   } coord_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [COORD_W-1:0]    req_coord_u = '0;
   logic [COORD_W-1:0]    req_coord_v = '0;
   logic                  rsp_strobe;
   logic [NOISE_W-1:0]    rsp_noise_value;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   // shadow of the block's registers
   logic [FREQ_W-1:0] model_base_freq = 11'd4;
   logic [CNT_W-1:0]  model_octaves   = 4'd4;
   logic [SEED_W-1:0] model_seed      = 32'd2654435769;

   coord_item_type     coord_queue[$];
   logic [NOISE_W-1:0] expected_noise[$];
   coord_item_type     cur_item;
   bit                 have_item = 1'b0;
   int                 gap_left = 0;
   int                 queued_count = 0;
   int                 accepted_count = 0;
   int                 checked_count = 0;
   int                 fail_count = 0;
   int                 config_count = 1;
   int                 idle_cycles = 0;
   logic [NOISE_W-1:0] want;

   tiling_value_noise_fbm dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_coord_u      (req_coord_u),
      .req_coord_v      (req_coord_v),
      .rsp_strobe       (rsp_strobe),
      .rsp_noise_value  (rsp_noise_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [23:0] lattice_corner(input logic [31:0] x, input logic [31:0] y,
                                                   input logic [31:0] seed);
      logic [31:0] h;
      h = x * K_X + y * K_Y + seed * K_SEED;
      h = (h ^ (h >> 13)) * K_MIX;
      h = h ^ (h >> 16);
      return h[23:0];
   endfunction

   // smoothstep of a 16-bit fraction, rounded to a weight in [0, 65536]
   function automatic logic [16:0] smooth_weight(input logic [15:0] t);
      logic [63:0] tt;
      logic [63:0] s;
      tt = {48'd0, t};
      s = tt * tt * (64'd196608 - 64'd2 * tt);
      s = (s + 64'd2147483648) >> 32;
      return s[16:0];
   endfunction

   function automatic logic [63:0] lerp_corner(input logic [63:0] a, input logic [63:0] b,
                                               input logic [63:0] w);
      return (a * (64'd65536 - w) + b * w + 64'd32768) >> 16;
   endfunction

   function automatic logic [63:0] octave_value(input logic [15:0] u, input logic [15:0] v,
                                                input logic [31:0] freq,
                                                input logic [31:0] seed);
      logic [63:0] ff;
      logic [63:0] px;
      logic [63:0] py;
      logic [31:0] x0;
      logic [31:0] y0;
      logic [31:0] x1;
      logic [31:0] y1;
      logic [63:0] lo;
      logic [63:0] hi;
      ff = {32'd0, freq};
      px = {48'd0, u} * ff;
      py = {48'd0, v} * ff;
      x0 = 32'((px >> 16) % ff);
      y0 = 32'((py >> 16) % ff);
      x1 = (x0 + 32'd1) % freq;
      y1 = (y0 + 32'd1) % freq;
      lo = lerp_corner({40'd0, lattice_corner(x0, y0, seed)},
                       {40'd0, lattice_corner(x1, y0, seed)},
                       {47'd0, smooth_weight(px[15:0])});
      hi = lerp_corner({40'd0, lattice_corner(x0, y1, seed)},
                       {40'd0, lattice_corner(x1, y1, seed)},
                       {47'd0, smooth_weight(px[15:0])});
      return lerp_corner(lo, hi, {47'd0, smooth_weight(py[15:0])});
   endfunction

   function automatic logic [NOISE_W-1:0] noise_predict(input logic [15:0] u,
                                                        input logic [15:0] v);
      logic [31:0] base;
      logic [31:0] seed_i;
      logic [63:0] acc;
      int unsigned n;
      base = (model_base_freq == '0) ? 32'd1 : {21'd0, model_base_freq};
      n = (model_octaves > OCT_LIMIT) ? OCT_LIMIT : model_octaves;
      acc = '0;
      for (int unsigned i = 0; i < n; i++) begin
         seed_i = model_seed + K_STEP * i;
         acc += octave_value(u, v, base << i, seed_i) << (OCT_LIMIT - 1 - i);
      end
      acc = (acc + 64'd32768) >> 16;
      if (acc > 64'd65535) begin
         acc = 64'd65535;
      end
      return acc[NOISE_W-1:0];
   endfunction

   // driver: present queued coordinates, honoring per-item gaps and drain holds
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_noise.push_back(noise_predict(req_coord_u, req_coord_v));
            accepted_count++;
         end
         if (!start || !busy) begin
            if (!have_item && coord_queue.size() != 0) begin
               cur_item = coord_queue.pop_front();
               gap_left = cur_item.gap;
               have_item = 1'b1;
            end
            if (have_item && gap_left == 0 &&
                !(cur_item.drain && expected_noise.size() != 0)) begin
               req_coord_u <= cur_item.u;
               req_coord_v <= cur_item.v;
               start <= 1'b1;
               have_item = 1'b0;
            end else begin
               if (gap_left > 0) begin
                  gap_left--;
               end
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobe must match the oldest expected sample
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_noise.size() == 0) begin
            $error("noise_value: no result expected, got %h", rsp_noise_value);
            fail_count++;
         end else begin
            want = expected_noise.pop_front();
            checked_count++;
            if (rsp_noise_value !== want) begin
               $error("noise_value: expected %h, actual %h", want, rsp_noise_value);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic add_item(input logic [15:0] u, input logic [15:0] v, input int gap,
                           input bit drain);
      coord_item_type item;
      item.u = u;
      item.v = v;
      item.gap = gap;
      item.drain = drain;
      coord_queue.push_back(item);
      queued_count++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_BASE_FREQUENCY: model_base_freq = data[FREQ_W-1:0];
         CSR_OCTAVE_COUNT:   model_octaves = data[CNT_W-1:0];
         CSR_HASH_SEED:      model_seed = data;
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // upper data bits are junk on purpose; the block must drop them
   task automatic set_config(input logic [10:0] base, input logic [3:0] octaves,
                             input logic [31:0] seed);
      write_csr(CSR_BASE_FREQUENCY, ($urandom & ~32'h7FF) | {21'd0, base});
      write_csr(CSR_OCTAVE_COUNT, ($urandom & ~32'hF) | {28'd0, octaves});
      write_csr(CSR_HASH_SEED, seed);
      config_count++;
   endtask

   task automatic wait_drained();
      while (coord_queue.size() != 0 || have_item || accepted_count != queued_count ||
             expected_noise.size() != 0) begin
         @(posedge clock);
      end
      repeat (12) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom) & 16'hF000;
         3: return 16'($urandom) | 16'h0FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [10:0] base;
      logic [3:0]  octaves;
      int          gap_mode;
      int          gap;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: corners, center and cell edges
      add_item(16'h0000, 16'h0000, 0, 1'b0);
      add_item(16'hFFFF, 16'hFFFF, 0, 1'b0);
      add_item(16'h0000, 16'hFFFF, 0, 1'b0);
      add_item(16'hFFFF, 16'h0000, 3, 1'b0);
      add_item(16'h8000, 16'h8000, 0, 1'b0);
      add_item(16'h4000, 16'h3FFF, 1, 1'b0);
      add_item(16'h0001, 16'hFFFE, 0, 1'b0);
      add_item(16'hAAAA, 16'h5555, 0, 1'b0);
      wait_drained();

      // zero frequency and no octaves: output must be zero
      set_config(11'd0, 4'd0, 32'd0);
      add_item(16'h1234, 16'hFEDC, 0, 1'b0);
      add_item(16'hFFFF, 16'hFFFF, 0, 1'b0);
      add_item(16'h5555, 16'hAAAA, 0, 1'b0);
      wait_drained();

      // highest frequency, octave count above the limit, unused index ignored
      set_config(11'd2047, 4'd15, 32'hFFFF_FFFF);
      write_csr(CSR_UNUSED, 32'hFFFF_FFFF);
      add_item(16'h0000, 16'h0000, 0, 1'b0);
      add_item(16'hFFFF, 16'hFFFF, 0, 1'b0);
      add_item(16'h0020, 16'h0021, 0, 1'b0);
      add_item(16'h8000, 16'h7FFF, 5, 1'b0);
      add_item(16'hFFFF, 16'h0001, 0, 1'b0);
      add_item(16'h3C3C, 16'hC3C3, 0, 1'b0);
      add_item(16'h0100, 16'hFF00, 0, 1'b1);
      wait_drained();

      // zero frequency maps to one, full octave count
      set_config(11'd0, 4'd8, 32'd0);
      add_item(16'h0000, 16'hFFFF, 0, 1'b0);
      add_item(16'h7FFF, 16'h8000, 0, 1'b0);
      add_item(16'hC000, 16'h4000, 0, 1'b0);
      add_item(16'hFFFF, 16'hFFFF, 0, 1'b0);
      wait_drained();

      set_config(11'd1024, 4'd1, 32'd2654435769);
      add_item(16'h0040, 16'h0040, 0, 1'b0);
      add_item(16'hFFC0, 16'h003F, 0, 1'b0);
      add_item(16'h9999, 16'h6666, 0, 1'b0);
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 7))
            0: base = 11'd0;
            1: base = 11'd2047;
            2: base = 11'd1024;
            3: base = 11'd1;
            4: base = 11'($urandom);
            default: base = 11'($urandom_range(2, 64));
         endcase
         if ($urandom_range(0, 3) == 0) begin
            octaves = 4'($urandom_range(0, 15));
         end else begin
            octaves = 4'($urandom_range(1, 8));
         end
         set_config(base, octaves, $urandom);
         gap_mode = $urandom_range(0, 2);
         for (int k = 0; k < 50; k++) begin
            case (gap_mode)
               0: gap = 0;
               1: gap = $urandom_range(0, 13);
               default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
            endcase
            add_item(pick_coord(), pick_coord(), gap, k == 25 || $urandom_range(0, 49) == 0);
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      $display("Checked %0d noise samples from %0d coordinate pairs over %0d register settings",
               checked_count, accepted_count, config_count);
      $display("Settings spanned base frequency 0 to 2047, 0 to 15 octaves, random seeds");
      if (fail_count == 0 && expected_noise.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
